### rtl/core/spc_pkg.sv
`default_nettype none
package spc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        SIDE_FRONT = 2'd0,
        SIDE_BACK  = 2'd1,
        SIDE_CROSS = 2'd2
    } t_side;

    typedef struct packed {
        t_side side;
        logic  zero;      // whole segment discarded
        logic  repl_end;  // crossing point replaces the end point
    } t_ctl;

endpackage
`default_nettype wire

### rtl/core/spc_if.sv
`default_nettype none
interface spc_seg_if #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
);
    localparam int NW = FRAC_BITS + 2;

    logic                          valid;
    logic                          ready;
    logic signed [NW-1:0]          normal_x;
    logic signed [NW-1:0]          normal_y;
    logic signed [NW-1:0]          normal_z;
    logic signed [COORD_WIDTH-1:0] plane_offset;
    logic                          keep_front;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;

    modport source (
        output valid, normal_x, normal_y, normal_z, plane_offset, keep_front,
               start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, plane_offset, keep_front,
               start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

interface spc_res_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    side_class;
    logic signed [COORD_WIDTH-1:0] out_start_x;
    logic signed [COORD_WIDTH-1:0] out_start_y;
    logic signed [COORD_WIDTH-1:0] out_start_z;
    logic signed [COORD_WIDTH-1:0] out_end_x;
    logic signed [COORD_WIDTH-1:0] out_end_y;
    logic signed [COORD_WIDTH-1:0] out_end_z;

    modport source (
        output valid, side_class, out_start_x, out_start_y, out_start_z,
               out_end_x, out_end_y, out_end_z,
        input  ready
    );
    modport sink (
        input  valid, side_class, out_start_x, out_start_y, out_start_z,
               out_end_x, out_end_y, out_end_z,
        output ready
    );
endinterface
`default_nettype wire

### rtl/core/spc_dist.sv
`default_nettype none
module spc_dist #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_vld,
    output logic                                   o_rdy,
    input  wire logic [3*(FRAC_BITS+2)-1:0]        i_norm,
    input  wire logic [COORD_WIDTH-1:0]            i_off,
    input  wire logic                              i_keep,
    input  wire logic [6*COORD_WIDTH-1:0]          i_pay,
    output logic                                   o_vld,
    input  wire logic                              i_rdy,
    output logic [FRAC_BITS+COORD_WIDTH+3:0]       o_a,
    output logic [FRAC_BITS+COORD_WIDTH+3:0]       o_b,
    output spc_pkg::t_ctl                          o_ctl,
    output logic [6*COORD_WIDTH-1:0]               o_pay
);
    import spc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NW = FRAC_BITS + 2;
    localparam int PW = NW + CW;
    localparam int DW = PW + 2;

    logic [2:0] r_vld;
    logic [2:0] en;

    assign en[2] = !r_vld[2] || i_rdy;
    assign en[1] = !r_vld[1] || en[2];
    assign en[0] = !r_vld[0] || en[1];
    assign o_rdy = en[0];
    assign o_vld = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_vld;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
        end
    end

    // stage 0: the six normal-by-coordinate products
    logic signed [PW-1:0] n_prod [6];
    logic signed [PW-1:0] r0_prod [6];
    logic [CW-1:0]        r0_off;
    logic                 r0_keep;
    logic [6*CW-1:0]      r0_pay;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_prod[j]   = PW'($signed(i_norm[j*NW +: NW])) * PW'($signed(i_pay[j*CW +: CW]));
            n_prod[j+3] = PW'($signed(i_norm[j*NW +: NW]))
                        * PW'($signed(i_pay[(j+3)*CW +: CW]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0] && i_vld) begin
            r0_prod <= n_prod;
            r0_off  <= i_off;
            r0_keep <= i_keep;
            r0_pay  <= i_pay;
        end
    end

    // stage 1: exact signed distances of both ends
    logic signed [DW-1:0] n_ds, n_de, w_offs;
    logic signed [DW-1:0] r1_ds, r1_de;
    logic                 r1_keep;
    logic [6*CW-1:0]      r1_pay;

    always_comb begin
        w_offs = DW'($signed(r0_off)) <<< FRAC_BITS;
        n_ds   = DW'(r0_prod[0]) + DW'(r0_prod[1]) + DW'(r0_prod[2]) - w_offs;
        n_de   = DW'(r0_prod[3]) + DW'(r0_prod[4]) + DW'(r0_prod[5]) - w_offs;
    end

    always_ff @(posedge i_clk) begin
        if (en[1] && r_vld[0]) begin
            r1_ds   <= n_ds;
            r1_de   <= n_de;
            r1_keep <= r0_keep;
            r1_pay  <= r0_pay;
        end
    end

    // stage 2: classify and form the divider operands
    logic          s_neg, e_neg, s_pos, e_pos;
    logic [DW-1:0] n_a, n_b, w_mde;
    t_ctl          n_ctl;

    always_comb begin
        s_neg = r1_ds[DW-1];
        e_neg = r1_de[DW-1];
        s_pos = !s_neg && (r1_ds != '0);
        e_pos = !e_neg && (r1_de != '0);
        n_a   = s_neg ? DW'(-r1_ds) : DW'(r1_ds);
        w_mde = e_neg ? DW'(-r1_de) : DW'(r1_de);
        n_b   = n_a + w_mde;
        n_ctl.repl_end = (s_pos == r1_keep);
        if (s_pos && e_pos) begin
            n_ctl.side = SIDE_FRONT;
            n_ctl.zero = !r1_keep;
        end else if (s_neg && e_neg) begin
            n_ctl.side = SIDE_BACK;
            n_ctl.zero = r1_keep;
        end else begin
            n_ctl.side = SIDE_CROSS;
            n_ctl.zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2] && r_vld[1]) begin
            o_a   <= n_a;
            o_b   <= n_b;
            o_ctl <= n_ctl;
            o_pay <= r1_pay;
        end
    end

endmodule
`default_nettype wire

### rtl/core/spc_div.sv
`default_nettype none
module spc_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_vld,
    output logic                                   o_rdy,
    input  wire logic [FRAC_BITS+COORD_WIDTH+3:0]  i_a,
    input  wire logic [FRAC_BITS+COORD_WIDTH+3:0]  i_b,
    input  wire spc_pkg::t_ctl                     i_ctl,
    input  wire logic [6*COORD_WIDTH-1:0]          i_pay,
    output logic                                   o_vld,
    input  wire logic                              i_rdy,
    output logic [FRAC_BITS:0]                     o_ratio,
    output spc_pkg::t_ctl                          o_ctl,
    output logic [6*COORD_WIDTH-1:0]               o_pay
);
    import spc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int BW = FRAC_BITS + COORD_WIDTH + 4;
    localparam int RW = FRAC_BITS + 1;
    localparam int ND = FRAC_BITS + 1;   // restoring steps, one per stage
    localparam int NS = ND + 1;          // plus the rounding stage
    localparam logic [RW-1:0] RATIO_ONE = RW'(1) << FRAC_BITS;

    logic [NS-1:0]   r_vld;
    logic [NS-1:0]   en;
    logic [BW-1:0]   r_rem [ND];
    logic [BW-1:0]   r_b   [ND];
    logic [RW-1:0]   r_q   [ND];
    t_ctl            r_ctl [NS];
    logic [6*CW-1:0] r_pay [NS];

    assign en[NS-1] = !r_vld[NS-1] || i_rdy;
    assign o_rdy    = en[0];
    assign o_vld    = r_vld[NS-1];
    assign o_ctl    = r_ctl[NS-1];
    assign o_pay    = r_pay[NS-1];

    genvar k;
    generate
        for (k = 0; k < NS - 1; k++) begin : g_en
            assign en[k] = !r_vld[k] || en[k+1];
        end

        for (k = 0; k < NS; k++) begin : g_vld
            logic w_prev;
            if (k == 0) begin : g_first
                assign w_prev = i_vld;
            end else begin : g_next
                assign w_prev = r_vld[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (en[k]) begin
                    r_vld[k] <= w_prev;
                end
            end
        end

        for (k = 0; k < ND; k++) begin : g_step
            logic [BW:0]   w_rem2;
            logic [BW-1:0] w_b;
            logic [RW-1:0] w_q;
            logic          w_bit;
            logic          w_load;
            t_ctl          w_ctl;
            logic [6*CW-1:0] w_pay;
            if (k == 0) begin : g_first
                // ratio never exceeds one, so the integer bit takes one compare
                assign w_rem2 = {1'b0, i_a};
                assign w_b    = i_b;
                assign w_q    = '0;
                assign w_load = en[0] && i_vld;
                assign w_ctl  = i_ctl;
                assign w_pay  = i_pay;
            end else begin : g_next
                assign w_rem2 = {r_rem[k-1], 1'b0};
                assign w_b    = r_b[k-1];
                assign w_q    = r_q[k-1];
                assign w_load = en[k] && r_vld[k-1];
                assign w_ctl  = r_ctl[k-1];
                assign w_pay  = r_pay[k-1];
            end
            assign w_bit = (w_rem2 >= {1'b0, w_b});
            always_ff @(posedge i_clk) begin
                if (w_load) begin
                    r_rem[k] <= BW'(w_rem2 - (w_bit ? {1'b0, w_b} : '0));
                    r_b[k]   <= w_b;
                    r_q[k]   <= {w_q[RW-2:0], w_bit};
                    r_ctl[k] <= w_ctl;
                    r_pay[k] <= w_pay;
                end
            end
        end
    endgenerate

    // rounding: half or more of the divisor left over rounds up
    logic w_rnd;
    assign w_rnd = ({r_rem[ND-1], 1'b0} >= {1'b0, r_b[ND-1]});

    always_ff @(posedge i_clk) begin
        if (en[NS-1] && r_vld[NS-2]) begin
            o_ratio        <= (r_b[ND-1] == '0) ? '0 : r_q[ND-1] + RW'(w_rnd);
            r_ctl[NS-1]    <= r_ctl[ND-1];
            r_pay[NS-1]    <= r_pay[ND-1];
        end
    end

`ifndef SYNTHESIS
    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] |-> o_ratio <= RATIO_ONE)
        else $error("ratio above one");
    a_num_le_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && o_rdy) |-> i_a <= i_b)
        else $error("dividend exceeds divisor");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && !i_rdy) |=> (r_vld[NS-1] && $stable(o_ratio)))
        else $error("stalled ratio lost");
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ND-1] && r_b[ND-1] != '0) |-> r_rem[ND-1] < r_b[ND-1])
        else $error("remainder not reduced");
`endif

endmodule
`default_nettype wire

### rtl/core/spc_lerp.sv
`default_nettype none
module spc_lerp #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    output logic                            o_rdy,
    input  wire logic [FRAC_BITS:0]         i_ratio,
    input  wire spc_pkg::t_ctl              i_ctl,
    input  wire logic [6*COORD_WIDTH-1:0]   i_pay,
    output logic                            o_vld,
    input  wire logic                       i_rdy,
    output logic [1:0]                      o_side,
    output logic [6*COORD_WIDTH-1:0]        o_pay
);
    import spc_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int RW  = FRAC_BITS + 1;
    localparam int PRW = CW + RW + 2;
    localparam logic signed [PRW-1:0] HALF = PRW'(64'd1 << (FRAC_BITS - 1));

    logic [1:0] r_vld;
    logic [1:0] en;

    assign en[1] = !r_vld[1] || i_rdy;
    assign en[0] = !r_vld[0] || en[1];
    assign o_rdy = en[0];
    assign o_vld = r_vld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_vld;
            if (en[1]) r_vld[1] <= r_vld[0];
        end
    end

    // stage 0: (end - start) * ratio per axis
    logic signed [CW:0]     w_dlt [3];
    logic signed [PRW-1:0]  n_prod [3];
    logic signed [PRW-1:0]  r_prod [3];
    t_ctl                   r_ctl;
    logic [6*CW-1:0]        r_pay;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_dlt[j]  = (CW+1)'($signed(i_pay[(j+3)*CW +: CW]))
                      - (CW+1)'($signed(i_pay[j*CW +: CW]));
            n_prod[j] = PRW'(w_dlt[j]) * PRW'($signed({1'b0, i_ratio}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0] && i_vld) begin
            r_prod <= n_prod;
            r_ctl  <= i_ctl;
            r_pay  <= i_pay;
        end
    end

    // stage 1: round, add to start, pick the endpoint to replace
    logic signed [PRW-1:0] w_sh;
    logic [CW-1:0]         w_ip;
    logic [6*CW-1:0]       n_pay;

    always_comb begin
        n_pay = r_pay;
        w_sh  = '0;
        w_ip  = '0;
        for (int j = 0; j < 3; j++) begin
            w_sh = (r_prod[j] + HALF) >>> FRAC_BITS;
            w_ip = r_pay[j*CW +: CW] + w_sh[CW-1:0];
            if (r_ctl.side == SIDE_CROSS) begin
                if (r_ctl.repl_end) n_pay[(j+3)*CW +: CW] = w_ip;
                else                n_pay[j*CW +: CW]     = w_ip;
            end
        end
        if (r_ctl.zero) n_pay = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[1] && r_vld[0]) begin
            o_side <= r_ctl.side;
            o_pay  <= n_pay;
        end
    end

endmodule
`default_nettype wire

### rtl/core/segment_plane_clip.sv
// segment_plane_clip: clips a line segment against a plane, keeping the
// front or back part.
// channels: i_seg carries one plane, one segment and the keep_front flag
// per transaction; o_res returns exactly one result per input transaction,
// in order: side_class and the clipped start and end points.
// stages: three stages form the distances and divider operands,
// FRAC_BITS + 2 stages hold the restoring divider, which forms the
// crossing ratio one bit per stage and then rounds it, and two stages
// interpolate.
// throughput: one transaction per cycle while o_res.ready is high; every
// stage is a full register stage with its own valid bit.
// stall: when o_res.ready is low the result holds in the output register;
// the stages behind it keep filling empty slots, and i_seg.ready falls
// only once every stage is occupied. nothing is dropped or repeated.
// reset: synchronous, active low, clears all valid bits; no other
// register is reset.
`default_nettype none
module segment_plane_clip #(
    parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = spc_pkg::FRAC_BITS_DEF
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    spc_seg_if.sink    i_seg,
    spc_res_if.source  o_res
);
    import spc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int BW = FRAC_BITS + COORD_WIDTH + 4;
    localparam int NW = FRAC_BITS + 2;

    logic            d_vld, d_rdy, v_vld, v_rdy;
    logic [BW-1:0]   d_a, d_b;
    t_ctl            d_ctl, v_ctl;
    logic [6*CW-1:0] d_pay, v_pay, w_pay, o_pay;
    logic [3*NW-1:0] w_norm;
    logic [FRAC_BITS:0] v_ratio;
    logic [1:0]      o_side;

    assign w_norm = {i_seg.normal_z, i_seg.normal_y, i_seg.normal_x};
    assign w_pay  = {i_seg.end_z, i_seg.end_y, i_seg.end_x,
                     i_seg.start_z, i_seg.start_y, i_seg.start_x};

    spc_dist #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_seg.valid),
        .o_rdy   (i_seg.ready),
        .i_norm  (w_norm),
        .i_off   (i_seg.plane_offset),
        .i_keep  (i_seg.keep_front),
        .i_pay   (w_pay),
        .o_vld   (d_vld),
        .i_rdy   (d_rdy),
        .o_a     (d_a),
        .o_b     (d_b),
        .o_ctl   (d_ctl),
        .o_pay   (d_pay)
    );

    spc_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d_vld),
        .o_rdy   (d_rdy),
        .i_a     (d_a),
        .i_b     (d_b),
        .i_ctl   (d_ctl),
        .i_pay   (d_pay),
        .o_vld   (v_vld),
        .i_rdy   (v_rdy),
        .o_ratio (v_ratio),
        .o_ctl   (v_ctl),
        .o_pay   (v_pay)
    );

    spc_lerp #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (v_vld),
        .o_rdy   (v_rdy),
        .i_ratio (v_ratio),
        .i_ctl   (v_ctl),
        .i_pay   (v_pay),
        .o_vld   (o_res.valid),
        .i_rdy   (o_res.ready),
        .o_side  (o_side),
        .o_pay   (o_pay)
    );

    assign o_res.side_class  = o_side;
    assign o_res.out_start_x = o_pay[0*CW +: CW];
    assign o_res.out_start_y = o_pay[1*CW +: CW];
    assign o_res.out_start_z = o_pay[2*CW +: CW];
    assign o_res.out_end_x   = o_pay[3*CW +: CW];
    assign o_res.out_end_y   = o_pay[4*CW +: CW];
    assign o_res.out_end_z   = o_pay[5*CW +: CW];

endmodule
`default_nettype wire

### dv/segment_plane_clip_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module segment_plane_clip_tb;
    import spc_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int NW = FB + 2;
    localparam int LATENCY = FB + 7;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [NW-1:0] nx, ny, nz;
        logic signed [CW-1:0] off;
        logic                 kf;
        logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
    } t_seg;

    typedef struct {
        t_side                side;
        logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
    } t_clip;

    // exact signed distance of a point to the plane, FB fraction bits
    function automatic logic signed [63:0] plane_distance(t_seg g, logic signed [CW-1:0] px,
            logic signed [CW-1:0] py, logic signed [CW-1:0] pz);
        logic signed [63:0] acc;
        acc = 64'(g.nx) * 64'(px) + 64'(g.ny) * 64'(py) + 64'(g.nz) * 64'(pz);
        return acc - (64'(g.off) <<< FB);
    endfunction

    function automatic logic [63:0] crossing_ratio(logic [63:0] a, logic [63:0] b);
        logic [63:0] q, rem;
        q = 0;
        rem = a;
        if (rem >= b) begin
            q = 1;
            rem -= b;
        end
        for (int i = 0; i < FB; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= b) begin
                rem -= b;
                q |= 1;
            end
        end
        if ((rem << 1) >= b) q += 1;
        return q;
    endfunction

    function automatic logic signed [CW-1:0] lerp_coord(logic signed [CW-1:0] s,
            logic signed [CW-1:0] e, logic [63:0] r);
        logic signed [63:0] v;
        v = (64'(e) - 64'(s)) * $signed(r) + (64'sd1 <<< (FB - 1));
        return CW'(64'(s) + (v >>> FB));
    endfunction

    function automatic t_clip clip_segment(t_seg g);
        t_clip c;
        logic signed [63:0] ds, de;
        logic [63:0] a, b, r;
        logic sp, sn, ep, en;
        logic signed [CW-1:0] ix, iy, iz;
        ds = plane_distance(g, g.sx, g.sy, g.sz);
        de = plane_distance(g, g.ex, g.ey, g.ez);
        sn = ds < 0;
        en = de < 0;
        sp = ds > 0;
        ep = de > 0;
        c.sx = g.sx; c.sy = g.sy; c.sz = g.sz;
        c.ex = g.ex; c.ey = g.ey; c.ez = g.ez;
        if (sp && ep) begin
            c.side = SIDE_FRONT;
            if (!g.kf) c = '{SIDE_FRONT, 0, 0, 0, 0, 0, 0};
        end else if (sn && en) begin
            c.side = SIDE_BACK;
            if (g.kf) c = '{SIDE_BACK, 0, 0, 0, 0, 0, 0};
        end else begin
            c.side = SIDE_CROSS;
            a = sn ? -ds : ds;
            b = a + (en ? -de : de);
            r = (b == 0) ? 64'd0 : crossing_ratio(a, b);
            ix = lerp_coord(g.sx, g.ex, r);
            iy = lerp_coord(g.sy, g.ey, r);
            iz = lerp_coord(g.sz, g.ez, r);
            if (sp == g.kf) begin
                c.ex = ix; c.ey = iy; c.ez = iz;
            end else begin
                c.sx = ix; c.sy = iy; c.sz = iz;
            end
        end
        return c;
    endfunction

    class clip_scoreboard;
        t_clip pending[$];
        int errors = 0;

        function void note_segment(t_seg g);
            pending.push_back(clip_segment(g));
        endfunction

        function void check_field(string name, logic [63:0] exp, logic [63:0] act);
            if (exp !== act) begin
                $error("%s expected %0h actual %0h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] side, logic signed [CW-1:0] sx,
                logic signed [CW-1:0] sy, logic signed [CW-1:0] sz,
                logic signed [CW-1:0] ex, logic signed [CW-1:0] ey,
                logic signed [CW-1:0] ez);
            t_clip c;
            if (pending.size() == 0) begin
                $error("result with no segment pending");
                errors++;
                return;
            end
            c = pending.pop_front();
            check_field("side_class", c.side, side);
            check_field("out_start_x", c.sx, sx);
            check_field("out_start_y", c.sy, sy);
            check_field("out_start_z", c.sz, sz);
            check_field("out_end_x", c.ex, ex);
            check_field("out_end_y", c.ey, ey);
            check_field("out_end_z", c.ez, ez);
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #1 i_clk = ~i_clk;

    spc_seg_if #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) seg_ch();
    spc_res_if #(.COORD_WIDTH(CW)) res_ch();

    segment_plane_clip #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_seg(seg_ch.sink), .o_res(res_ch.source)
    );

    clip_scoreboard sb = new();
    int send_idle = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;

    initial begin
        seg_ch.valid = 0;
        seg_ch.normal_x = 0; seg_ch.normal_y = 0; seg_ch.normal_z = 0;
        seg_ch.plane_offset = 0; seg_ch.keep_front = 0;
        seg_ch.start_x = 0; seg_ch.start_y = 0; seg_ch.start_z = 0;
        seg_ch.end_x = 0; seg_ch.end_y = 0; seg_ch.end_z = 0;
        res_ch.ready = 0;
    end

    // receiver with random stalls; results checked at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.side_class, res_ch.out_start_x, res_ch.out_start_y,
                res_ch.out_start_z, res_ch.out_end_x, res_ch.out_end_y, res_ch.out_end_z);
        if ((i_rst_n && res_ch.valid && res_ch.ready) || (seg_ch.valid && seg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        res_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays high between back-to-back transactions
    task automatic send_segment(t_seg g);
        while ($urandom_range(99) < send_idle) begin
            seg_ch.valid <= 0;
            @(posedge i_clk);
        end
        seg_ch.valid <= 1;
        seg_ch.normal_x <= g.nx; seg_ch.normal_y <= g.ny; seg_ch.normal_z <= g.nz;
        seg_ch.plane_offset <= g.off; seg_ch.keep_front <= g.kf;
        seg_ch.start_x <= g.sx; seg_ch.start_y <= g.sy; seg_ch.start_z <= g.sz;
        seg_ch.end_x <= g.ex; seg_ch.end_y <= g.ey; seg_ch.end_z <= g.ez;
        do @(posedge i_clk); while (!seg_ch.ready);
        sb.note_segment(g);
    endtask

    function automatic logic signed [NW-1:0] rand_normal();
        case ($urandom_range(5))
            0: return NW'(65536);
            1: return -NW'(65536);
            2: return 0;
            3: return NW'($urandom);
            default: return NW'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(2000000)) - 1000000;
            default: return $signed($urandom_range(64)) - 32;
        endcase
    endfunction

    function automatic t_seg rand_segment();
        t_seg g;
        int m;
        m = $urandom_range(2);
        g.nx = rand_normal(); g.ny = rand_normal(); g.nz = rand_normal();
        g.off = rand_coord(m); g.kf = $urandom;
        g.sx = rand_coord(m); g.sy = rand_coord(m); g.sz = rand_coord(m);
        g.ex = rand_coord(m); g.ey = rand_coord(m); g.ez = rand_coord(m);
        return g;
    endfunction

    task automatic directed_segments();
        localparam logic signed [CW-1:0] MX = 32'h7fffffff;
        localparam logic signed [CW-1:0] MN = 32'h80000000;
        localparam logic signed [NW-1:0] ONE = 65536;
        for (int k = 0; k < 2; k++) begin
            // wholly front, wholly back, crossing, each side kept
            send_segment('{ONE, 0, 0, 0, k, 65536, 5, 6, 131072, 7, 8});
            send_segment('{ONE, 0, 0, 0, k, -65536, 5, 6, -131072, 7, 8});
            send_segment('{ONE, 0, 0, 0, k, -65536, 1, 2, 196608, 3, 4});
            send_segment('{ONE, 0, 0, 0, k, 196608, 1, 2, -65536, 3, 4});
            // coplanar segment
            send_segment('{0, ONE, 0, 0, k, 123, 0, 9, -77, 0, 1000});
            // endpoint exactly on the plane
            send_segment('{0, 0, ONE, 65536, k, 5, 5, 65536, 9, 9, 262144});
            send_segment('{0, 0, -ONE, 0, k, 5, 5, 0, 9, 9, -5});
            // coordinate and offset extremes
            send_segment('{ONE, -ONE, ONE, MX, k, MN, MX, MN, MX, MN, MX});
            send_segment('{-ONE, ONE, -ONE, MN, k, MX, MN, MX, MN, MX, MN});
            // out-of-range normal patterns
            send_segment('{18'h1ffff, 18'h20000, 18'h3ffff, MN, k, MX, MX, MX, MN, MN, MN});
            send_segment('{18'h20000, 18'h1ffff, 18'h2aaaa, 0, k, -1, 1, -1, 1, -1, 1});
        end
    endtask

    initial begin
        int idle_pct[4][2];
        idle_pct = '{'{0, 0}, '{61, 0}, '{0, 61}, '{23, 23}};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        directed_segments();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = idle_pct[ph][0];
            recv_stall = idle_pct[ph][1];
            for (int n = 0; n < 190; n++) send_segment(rand_segment());
        end
        seg_ch.valid <= 0;
        send_idle = 0;
        recv_stall = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
